/* hdl/assert_macros.svh */
// ============================================================================
// assert_macros.svh
// Assertion macros shared by the boundary splitter RTL. Assertions are
// compiled in simulation only; synthesis sees empty bodies.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge
`define MBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbs assertion failed");

// Next-cycle implication
`define MBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbs assertion failed");

`else

`define MBS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MBS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/mbs_pkg.sv */
// ============================================================================
// mbs_pkg
// Types and constants shared by the MIME boundary splitter modules.
// ============================================================================
package mbs_pkg;

    // Boundary store and field widths
    localparam int MAX_BOUNDARY = 70;
    localparam int BIDX_W       = 7;
    localparam int BLEN_W       = 7;
    localparam int OFFSET_WIDTH = 32;
    localparam int MODE_W       = 2;

    // Input transaction modes
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_END   = 2'd3;

    // Characters of interest
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;

    // Result record kinds
    localparam logic KIND_SPAN = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Output record buffer (end of body emits up to three records)
    localparam int SLOT_COUNT = 3;

    // Register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_BOUNDARY_LENGTH = 1'd0;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [BIDX_W-1:0]       boundary_index;
        logic [7:0]              data_byte;
        logic [OFFSET_WIDTH-1:0] body_offset;
    } mbs_item_t;

    typedef struct packed {
        logic                    record_kind;
        logic [OFFSET_WIDTH-1:0] segment_begin;
        logic [OFFSET_WIDTH-1:0] segment_end;
        logic                    no_delimiter;
        logic                    last;
    } mbs_result_t;

    // Classified command carried through the queue
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [BIDX_W-1:0]       bidx;
        logic [7:0]              data;
        logic [OFFSET_WIDTH-1:0] offset;
        logic                    is_cr;
        logic                    is_lf;
        logic                    is_dash;
        logic                    is_ws;
        logic                    idx_ok;
    } mbs_cmd_t;

    // Back end status seen by the top level
    typedef struct packed {
        logic [SLOT_COUNT-1:0] slot_valid;
        logic                  popped;
    } mbs_back_status_t;

endpackage

/* hdl/mime_boundary_splitter.sv */
// A transaction waits in the command queue; its records then load the output buffer.
// Throughput: one transaction per cycle while the queue has room; an end of body emits
// up to three records, one per cycle while result_stall is low, and the scan engine
// waits for the output buffer to drain first. Reset: scan state cleared with a body scan
// at offset 0 under way, boundary_length = 1, boundary store contents are not cleared.
// Command queue holds four transactions between classifier and scan engine.
// ============================================================================
// mime_boundary_splitter
// MIME multipart delimiter scanner: classifier front, command queue, scan
// engine back, and the APB register for the boundary length.
// ============================================================================
`include "assert_macros.svh"

module mime_boundary_splitter import mbs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    // Input transactions
    input  logic                  item_valid,
    output logic                  item_stall,
    input  mbs_item_t             item,
    // Result transactions
    output logic                  result_valid,
    input  logic                  result_stall,
    output mbs_result_t           result,
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic              queue_full;
    logic              push;
    mbs_cmd_t          push_cmd;
    logic              pop;
    logic              head_valid;
    mbs_cmd_t          head_cmd;
    mbs_back_status_t  back_status;
    logic [BLEN_W-1:0] boundary_length_reg, boundary_length_next;
    logic [REG_IDX_W-1:0] reg_index;
    logic              reg_write;

    // Register access
    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign reg_write = psel && penable && pwrite && pready &&
                       (reg_index == REG_BOUNDARY_LENGTH);
    assign boundary_length_next = reg_write ? pwdata[BLEN_W-1:0] : boundary_length_reg;
    assign prdata = (reg_index == REG_BOUNDARY_LENGTH) ?
                    APB_DATA_W'(boundary_length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            boundary_length_reg <= BLEN_W'(1);
        else
            boundary_length_reg <= boundary_length_next;
    end

    mbs_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    mbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    mbs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .boundary_length (boundary_length_reg),
        .head_valid      (head_valid),
        .head_cmd        (head_cmd),
        .pop             (pop),
        .result_valid    (result_valid),
        .result          (result),
        .result_stall    (result_stall),
        .status          (back_status)
    );

    // Output buffer fills from the front slot with no holes
    `MBS_ASSERT_IMP(a_slot1_packed, clk, rst_n, back_status.slot_valid[1], back_status.slot_valid[0])
    `MBS_ASSERT_IMP(a_slot2_packed, clk, rst_n, back_status.slot_valid[2], back_status.slot_valid[1])
    // A done record closes the records of its transaction and carries no span
    `MBS_ASSERT_IMP(a_done_last, clk, rst_n, result_valid && (result.record_kind == KIND_DONE), result.last)
    `MBS_ASSERT_IMP(a_done_zero, clk, rst_n, result_valid && (result.record_kind == KIND_DONE), (result.segment_begin == '0) && (result.segment_end == '0))

endmodule

/* hdl/mbs_ram.sv */
// ============================================================================
// mbs_ram
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
// ============================================================================
module mbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 70
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/mbs_front.sv */
// ============================================================================
// mbs_front
// Accepts input transactions and classifies them into queue commands:
// terminator, dash and blank detection, boundary index range check.
// ============================================================================
module mbs_front import mbs_pkg::*; (
    input  logic      item_valid,
    output logic      item_stall,
    input  mbs_item_t item,
    input  logic      queue_full,
    output logic      push,
    output mbs_cmd_t  push_cmd
);

    // Hold off the source while the queue has no room
    assign item_stall = queue_full;
    assign push       = item_valid && !queue_full;

    // Byte classification
    always_comb
    begin
        push_cmd.mode    = item.mode;
        push_cmd.bidx    = item.boundary_index;
        push_cmd.data    = item.data_byte;
        push_cmd.offset  = item.body_offset;
        push_cmd.is_cr   = (item.data_byte == CHAR_CR);
        push_cmd.is_lf   = (item.data_byte == CHAR_LF);
        push_cmd.is_dash = (item.data_byte == CHAR_DASH);
        push_cmd.is_ws   = (item.data_byte == CHAR_SPACE) || (item.data_byte == CHAR_TAB);
        push_cmd.idx_ok  = (item.boundary_index < BIDX_W'(MAX_BOUNDARY));
    end

endmodule

/* hdl/mbs_queue.sv */
// ============================================================================
// mbs_queue
// Small register FIFO decoupling the classifier from the scan engine.
// ============================================================================
module mbs_queue import mbs_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  mbs_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output mbs_cmd_t head_cmd
);

    mbs_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/mbs_back.sv */
// ============================================================================
// mbs_back
// Scan engine: loads the boundary store, tracks line matching state, emits
// segment spans and done records through a three-slot output buffer.
// ============================================================================
module mbs_back import mbs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BLEN_W-1:0] boundary_length,
    input  logic              head_valid,
    input  mbs_cmd_t          head_cmd,
    output logic              pop,
    output logic              result_valid,
    output mbs_result_t       result,
    input  logic              result_stall,
    output mbs_back_status_t  status
);

    // Line match phases
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_PREFIX   = 3'd0;
    localparam logic [PH_W-1:0] PH_BOUNDARY = 3'd1;
    localparam logic [PH_W-1:0] PH_AFTER    = 3'd2;
    localparam logic [PH_W-1:0] PH_SPACES   = 3'd3;
    localparam logic [PH_W-1:0] PH_DASH1    = 3'd4;
    localparam logic [PH_W-1:0] PH_CLOSE    = 3'd5;
    localparam logic [PH_W-1:0] PH_FAIL     = 3'd6;

    // Scan state
    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;
    logic [OFFSET_WIDTH-1:0] line_start_reg, line_start_next;
    logic [OFFSET_WIDTH-1:0] seg_start_reg, seg_start_next;
    logic [BIDX_W-1:0]       match_idx_reg, match_idx_next;
    logic [PH_W-1:0]         phase_reg, phase_next;
    logic                    seg_open_reg, seg_open_next;
    logic                    after_cr_reg, after_cr_next;
    logic                    pend_reg, pend_next;
    logic                    closed_reg, closed_next;
    logic                    any_reg, any_next;

    // Boundary store bypass for a write to the address being read
    logic                    byp_hit_reg, byp_hit_next;
    logic [7:0]              byp_byte_reg;
    logic                    ram_wr_en;
    logic [7:0]              ram_rd_data;
    logic [7:0]              store_byte;

    // Output buffer
    mbs_result_t             slot_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]   slot_valid_reg, slot_valid_next;
    mbs_result_t             load_rec [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]   load_valid;
    logic                    load;
    logic                    out_take;

    // Per-command decode
    logic [BLEN_W-1:0]       eff_len;
    logic [BIDX_W-1:0]       match_idx_inc;
    logic [PH_W-1:0]         adv_phase;
    logic [BIDX_W-1:0]       adv_idx;
    logic [OFFSET_WIDTH-1:0] nxt;
    logic [OFFSET_WIDTH-1:0] fin_start;
    logic [OFFSET_WIDTH-1:0] seg_start_fin;
    logic                    is_plain, is_closing, is_delim;
    logic                    open_fin, any_fin;
    logic                    crlf_tail, term;
    logic                    rec_a_ok, rec_b_ok;
    logic                    emit_a, emit_b;
    logic                    has_rec, drain_ok;
    logic                    pend_new;
    mbs_result_t             rec_a, rec_b, rec_d;

    mbs_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BOUNDARY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (head_cmd.bidx),
        .wr_data (head_cmd.data),
        .rd_addr (match_idx_next),
        .rd_data (ram_rd_data)
    );

    assign store_byte = byp_hit_reg ? byp_byte_reg : ram_rd_data;
    assign eff_len    = (boundary_length > BLEN_W'(MAX_BOUNDARY)) ?
                        BLEN_W'(MAX_BOUNDARY) : boundary_length;
    assign match_idx_inc = match_idx_reg + 1'b1;

    // Match advance on an ordinary body byte
    always_comb
    begin
        adv_phase = phase_reg;
        adv_idx   = match_idx_reg;
        unique case (phase_reg)
            PH_PREFIX:
            begin
                if (!head_cmd.is_dash)
                    adv_phase = PH_FAIL;
                else if (match_idx_reg == '0)
                    adv_idx = BIDX_W'(1);
                else if (eff_len == '0)
                    adv_phase = PH_AFTER;
                else
                begin
                    adv_phase = PH_BOUNDARY;
                    adv_idx   = '0;
                end
            end
            PH_BOUNDARY:
            begin
                if ((match_idx_reg < eff_len) && (match_idx_reg < BIDX_W'(MAX_BOUNDARY)) &&
                    (head_cmd.data == store_byte))
                begin
                    adv_idx = match_idx_inc;
                    if (match_idx_inc >= eff_len)
                        adv_phase = PH_AFTER;
                end
                else
                    adv_phase = PH_FAIL;
            end
            PH_AFTER:
            begin
                if (head_cmd.is_dash)
                    adv_phase = PH_DASH1;
                else if (head_cmd.is_ws)
                    adv_phase = PH_SPACES;
                else
                    adv_phase = PH_FAIL;
            end
            PH_SPACES, PH_CLOSE:
            begin
                if (!head_cmd.is_ws)
                    adv_phase = PH_FAIL;
            end
            PH_DASH1:
            begin
                adv_phase = head_cmd.is_dash ? PH_CLOSE : PH_FAIL;
            end
            default:
            begin
                adv_phase = PH_FAIL;
            end
        endcase
    end

    // Line finish: delimiter test and segment bookkeeping
    always_comb
    begin
        nxt           = pos_reg + 1'b1;
        is_plain      = (phase_reg == PH_AFTER) || (phase_reg == PH_SPACES);
        is_closing    = (phase_reg == PH_CLOSE);
        is_delim      = is_plain || is_closing;
        fin_start     = (head_cmd.mode == MODE_END) ? pos_reg : nxt;
        seg_start_fin = is_plain ? fin_start : seg_start_reg;
        open_fin      = is_closing ? 1'b0 : (is_plain ? 1'b1 : seg_open_reg);
        any_fin       = any_reg || is_delim;
        crlf_tail     = !closed_reg && after_cr_reg && head_cmd.is_lf;
        term          = !closed_reg && !crlf_tail && (head_cmd.is_cr || head_cmd.is_lf);
        rec_a_ok      = is_delim && seg_open_reg;
        rec_b_ok      = !is_closing && open_fin;
        pend_new      = !is_closing && open_fin && head_cmd.is_cr &&
                        (is_plain || (seg_start_reg == nxt));
        emit_a        = !closed_reg && rec_a_ok;
        emit_b        = !closed_reg && rec_b_ok;

        rec_a.record_kind   = KIND_SPAN;
        rec_a.segment_begin = seg_start_reg;
        rec_a.segment_end   = line_start_reg;
        rec_a.no_delimiter  = 1'b0;
        rec_a.last          = (head_cmd.mode == MODE_BYTE);

        rec_b.record_kind   = KIND_SPAN;
        rec_b.segment_begin = seg_start_fin;
        rec_b.segment_end   = pos_reg;
        rec_b.no_delimiter  = 1'b0;
        rec_b.last          = 1'b0;

        rec_d.record_kind   = KIND_DONE;
        rec_d.segment_begin = '0;
        rec_d.segment_end   = '0;
        rec_d.no_delimiter  = closed_reg ? !any_reg : !any_fin;
        rec_d.last          = 1'b1;
    end

    // Issue control: a command with records waits for a drained buffer
    assign out_take = slot_valid_reg[0] && !result_stall;
    assign drain_ok = !slot_valid_reg[0] || (out_take && !slot_valid_reg[1]);
    assign has_rec  = ((head_cmd.mode == MODE_BYTE) && term && rec_a_ok) ||
                      (head_cmd.mode == MODE_END);
    assign pop      = head_valid && (!has_rec || drain_ok);
    assign load     = pop && has_rec;
    assign ram_wr_en = pop && (head_cmd.mode == MODE_LOAD) && head_cmd.idx_ok;
    assign byp_hit_next = ram_wr_en && (head_cmd.bidx == match_idx_next);

    // Records to load, packed in emission order
    always_comb
    begin
        load_rec[0] = rec_d;
        load_rec[1] = rec_d;
        load_rec[2] = rec_d;
        load_valid  = 3'b001;
        if (head_cmd.mode == MODE_BYTE)
        begin
            load_rec[0] = rec_a;
        end
        else
        begin
            unique case ({emit_a, emit_b})
                2'b11:
                begin
                    load_rec[0] = rec_a;
                    load_rec[1] = rec_b;
                    load_valid  = 3'b111;
                end
                2'b10:
                begin
                    load_rec[0] = rec_a;
                    load_valid  = 3'b011;
                end
                2'b01:
                begin
                    load_rec[0] = rec_b;
                    load_valid  = 3'b011;
                end
                default:
                begin
                    load_valid  = 3'b001;
                end
            endcase
        end
    end

    // Scan state update
    always_comb
    begin
        pos_next        = pos_reg;
        line_start_next = line_start_reg;
        seg_start_next  = seg_start_reg;
        match_idx_next  = match_idx_reg;
        phase_next      = phase_reg;
        seg_open_next   = seg_open_reg;
        after_cr_next   = after_cr_reg;
        pend_next       = pend_reg;
        closed_next     = closed_reg;
        any_next        = any_reg;
        if (pop)
        begin
            unique case (head_cmd.mode)
                MODE_LOAD:
                begin
                    // store write only
                end
                MODE_START:
                begin
                    pos_next        = head_cmd.offset;
                    line_start_next = head_cmd.offset;
                    seg_start_next  = '0;
                    match_idx_next  = '0;
                    phase_next      = PH_PREFIX;
                    seg_open_next   = 1'b0;
                    after_cr_next   = 1'b0;
                    pend_next       = 1'b0;
                    closed_next     = 1'b0;
                    any_next        = 1'b0;
                end
                MODE_BYTE:
                begin
                    if (crlf_tail)
                    begin
                        // LF completing a CRLF terminator
                        if (pend_reg)
                            seg_start_next = nxt;
                        after_cr_next   = 1'b0;
                        pend_next       = 1'b0;
                        line_start_next = nxt;
                        pos_next        = nxt;
                    end
                    else if (!closed_reg)
                    begin
                        after_cr_next = 1'b0;
                        pend_next     = 1'b0;
                        if (term)
                        begin
                            any_next        = any_fin;
                            seg_start_next  = seg_start_fin;
                            seg_open_next   = open_fin;
                            closed_next     = is_closing;
                            phase_next      = PH_PREFIX;
                            match_idx_next  = '0;
                            pend_next       = pend_new;
                            after_cr_next   = head_cmd.is_cr;
                            line_start_next = nxt;
                        end
                        else
                        begin
                            phase_next     = adv_phase;
                            match_idx_next = adv_idx;
                        end
                        pos_next = nxt;
                    end
                end
                MODE_END:
                begin
                    if (!closed_reg)
                    begin
                        any_next       = any_fin;
                        seg_start_next = seg_start_fin;
                    end
                    closed_next    = 1'b1;
                    seg_open_next  = 1'b0;
                    after_cr_next  = 1'b0;
                    pend_next      = 1'b0;
                    phase_next     = PH_PREFIX;
                    match_idx_next = '0;
                end
            endcase
        end
    end

    // Output buffer occupancy
    always_comb
    begin
        if (load)
            slot_valid_next = load_valid;
        else if (out_take)
            slot_valid_next = {1'b0, slot_valid_reg[SLOT_COUNT-1:1]};
        else
            slot_valid_next = slot_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            line_start_reg <= '0;
            seg_start_reg  <= '0;
            match_idx_reg  <= '0;
            phase_reg      <= PH_PREFIX;
            seg_open_reg   <= 1'b0;
            after_cr_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            closed_reg     <= 1'b0;
            any_reg        <= 1'b0;
            byp_hit_reg    <= 1'b0;
            slot_valid_reg <= '0;
        end
        else
        begin
            pos_reg        <= pos_next;
            line_start_reg <= line_start_next;
            seg_start_reg  <= seg_start_next;
            match_idx_reg  <= match_idx_next;
            phase_reg      <= phase_next;
            seg_open_reg   <= seg_open_next;
            after_cr_reg   <= after_cr_next;
            pend_reg       <= pend_next;
            closed_reg     <= closed_next;
            any_reg        <= any_next;
            byp_hit_reg    <= byp_hit_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byp_byte_reg <= head_cmd.data;
        if (load)
        begin
            slot_reg[0] <= load_rec[0];
            slot_reg[1] <= load_rec[1];
            slot_reg[2] <= load_rec[2];
        end
        else if (out_take)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    assign result_valid      = slot_valid_reg[0];
    assign result            = slot_reg[0];
    assign status.slot_valid = slot_valid_reg;
    assign status.popped     = pop;

endmodule
